>>> rtl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion block.
// Used by the interfaces, the front, the queue and the back pipeline.
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int FIELD_W       = 18;
  localparam int NUM_W         = FIELD_W + 1;
  localparam int RAD_W         = 33;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  localparam logic [FIELD_W-1:0] Q_MAX = 18'h1FFFF;
  localparam logic [FIELD_W-1:0] Q_MIN = 18'h20000;

  typedef struct packed {
    logic [1:0]              branch;
    logic                    bad;
    logic signed [NUM_W-1:0] n0;
    logic signed [NUM_W-1:0] n1;
    logic signed [NUM_W-1:0] n2;
  } rmq_info_t;

  typedef struct packed {
    rmq_info_t               info;
    logic signed [RAD_W-1:0] rad;
  } rmq_job_t;

endpackage

>>> rtl/rmq_if.sv
// Channel interfaces: matrix in, quaternion out.
// Depends on rmq_pkg for field widths.
interface rmq_mat_if import rmq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

interface rmq_quat_if import rmq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] qx, qy, qz, qw;
  logic [1:0]                branch_taken;
  logic                      invalid;
  modport source(output valid, qx, qy, qz, qw, branch_taken, invalid, input ready);
  modport sink(input valid, qx, qy, qz, qw, branch_taken, invalid, output ready);
endinterface

>>> rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion, fixed point, one matrix per cycle unless stalled.
// The back pipeline has one square root stage per bit of ROOT_W, the root width.
// Throughput: one item per cycle; a stalled output stalls the back pipeline.
// Reset (rst, synchronous) empties the front register, queue and pipeline.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rmq_mat_if.sink    mat,
  rmq_quat_if.source quat
);

  logic     push_valid;
  logic     push_ready;
  rmq_job_t push_data;
  logic     pop_valid;
  logic     pop_ready;
  rmq_job_t pop_data;

  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .mat        (mat),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rmq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .quat      (quat)
  );

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    quat.valid && quat.invalid |->
      quat.qx == '0 && quat.qy == '0 && quat.qz == '0 && quat.qw == '0)
    else $error("invalid result with nonzero components");

  a_trace_valid: assert property (@(posedge clk) disable iff (rst)
    quat.valid && quat.branch_taken == BR_TRACE |-> !quat.invalid)
    else $error("trace path flagged invalid");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !quat.valid)
    else $error("result valid right after reset");

endmodule

>>> rtl/rmq_front.sv
// Front: accepts a matrix, picks the branch, forms radicand and numerators.
// Depends on rmq_pkg and rmq_mat_if.
module rmq_front import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  rmq_mat_if.sink  mat,
  output logic     push_valid,
  input  logic     push_ready,
  output rmq_job_t push_data
);

  logic     vld;
  rmq_job_t job;
  rmq_job_t job_next;

  logic signed [RAD_W-1:0] a00, a11, a22, one, tr;

  always_comb begin
    a00 = RAD_W'(mat.m00);
    a11 = RAD_W'(mat.m11);
    a22 = RAD_W'(mat.m22);
    one = RAD_W'(1) << FRAC_BITS;
    tr  = a00 + a11 + a22 + one;
    if (tr > 0) begin
      job_next.info.branch = BR_TRACE;
      job_next.rad         = tr;
      job_next.info.n0     = NUM_W'(mat.m12) - NUM_W'(mat.m21);
      job_next.info.n1     = NUM_W'(mat.m20) - NUM_W'(mat.m02);
      job_next.info.n2     = NUM_W'(mat.m01) - NUM_W'(mat.m10);
    end else if (mat.m00 > mat.m11 && mat.m00 > mat.m22) begin
      job_next.info.branch = BR_X;
      job_next.rad         = one + a00 - a11 - a22;
      job_next.info.n0     = NUM_W'(mat.m10) + NUM_W'(mat.m01);
      job_next.info.n1     = NUM_W'(mat.m20) + NUM_W'(mat.m02);
      job_next.info.n2     = NUM_W'(mat.m12) - NUM_W'(mat.m21);
    end else if (mat.m11 > mat.m22) begin
      job_next.info.branch = BR_Y;
      job_next.rad         = one + a11 - a00 - a22;
      job_next.info.n0     = NUM_W'(mat.m10) + NUM_W'(mat.m01);
      job_next.info.n1     = NUM_W'(mat.m21) + NUM_W'(mat.m12);
      job_next.info.n2     = NUM_W'(mat.m20) - NUM_W'(mat.m02);
    end else begin
      job_next.info.branch = BR_Z;
      job_next.rad         = one + a22 - a00 - a11;
      job_next.info.n0     = NUM_W'(mat.m20) + NUM_W'(mat.m02);
      job_next.info.n1     = NUM_W'(mat.m21) + NUM_W'(mat.m12);
      job_next.info.n2     = NUM_W'(mat.m01) - NUM_W'(mat.m10);
    end
    job_next.info.bad = (job_next.rad <= 0);
  end

  assign mat.ready  = !vld || push_ready;
  assign push_valid = vld;
  assign push_data  = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (mat.ready) begin
      vld <= mat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mat.valid && mat.ready) begin
      job <= job_next;
    end
  end

endmodule

>>> rtl/rmq_queue.sv
// Two-entry queue between the front and the back pipeline.
// Depends on rmq_pkg for the job type.
module rmq_queue import rmq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  rmq_job_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output rmq_job_t pop_data
);

  rmq_job_t   mem [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/rmq_back.sv
// Back: pipelined square root, then three pipelined dividers and saturation.
// Depends on rmq_pkg and rmq_quat_if.
module rmq_back import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  rmq_job_t  pop_data,
  rmq_quat_if.source quat
);

  localparam int POS_W  = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 2;
  localparam int ROOT_W = (POS_W + FRAC_BITS + 1) / 2;
  localparam int V_W    = 2 * ROOT_W;
  localparam int RW     = ROOT_W + 3;
  localparam int NW     = ((NUM_W + FRAC_BITS > ROOT_W) ? NUM_W + FRAC_BITS : ROOT_W) + 1;
  localparam int CW     = ((NW > ROOT_W + 19) ? NW : ROOT_W + 19) + 1;
  localparam int QB     = FIELD_W;

  logic adv;
  logic out_vld;

  assign adv       = !out_vld || quat.ready;
  assign pop_ready = adv;

  // square root stages
  logic              sq_vld  [1:ROOT_W];
  logic [V_W-1:0]    sq_v    [1:ROOT_W];
  logic [RW-1:0]     sq_rem  [1:ROOT_W];
  logic [ROOT_W-1:0] sq_root [1:ROOT_W];
  rmq_info_t         sq_info [1:ROOT_W];

  logic [V_W-1:0] v0;
  assign v0 = pop_data.info.bad ? '0 : (V_W'(pop_data.rad[POS_W-1:0]) << FRAC_BITS);

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    logic              cvld;
    logic [V_W-1:0]    cv;
    logic [RW-1:0]     crem;
    logic [ROOT_W-1:0] croot;
    rmq_info_t         cinfo;
    logic [RW-1:0]     rem2;
    logic [RW-1:0]     trial;

    if (i == 0) begin : g_head
      assign cvld  = pop_valid;
      assign cv    = v0;
      assign crem  = '0;
      assign croot = '0;
      assign cinfo = pop_data.info;
    end else begin : g_body
      assign cvld  = sq_vld[i];
      assign cv    = sq_v[i];
      assign crem  = sq_rem[i];
      assign croot = sq_root[i];
      assign cinfo = sq_info[i];
    end

    assign rem2  = {crem[RW-3:0], cv[V_W-1 -: 2]};
    assign trial = RW'({croot, 2'b01});

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[i+1] <= 1'b0;
      end else if (adv) begin
        sq_vld[i+1] <= cvld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_v[i+1]    <= cv << 2;
        sq_info[i+1] <= cinfo;
        if (rem2 >= trial) begin
          sq_rem[i+1]  <= rem2 - trial;
          sq_root[i+1] <= {croot[ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem[i+1]  <= rem2;
          sq_root[i+1] <= {croot[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // divider setup: numerators, divisor, leading component
  logic              pp_vld;
  rmq_info_t         pp_info;
  logic [ROOT_W-1:0] pp_lead;
  logic [2:0][CW-1:0] pp_n;
  logic [CW-1:0]     pp_d;
  logic [2:0]        pp_neg;

  logic [ROOT_W-1:0]     s_root;
  rmq_info_t             s_info;
  rmq_info_t             s_info_chk;
  logic [2:0][NUM_W-1:0] s_num;

  assign s_root = sq_root[ROOT_W];
  assign s_info = sq_info[ROOT_W];
  assign s_num  = {s_info.n2, s_info.n1, s_info.n0};

  // a zero root cannot divide: flag the beat as bad
  always_comb begin
    s_info_chk     = s_info;
    s_info_chk.bad = s_info.bad || (s_root == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_vld <= 1'b0;
    end else if (adv) begin
      pp_vld <= sq_vld[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pp_info     <= s_info_chk;
      pp_lead     <= ROOT_W'(((ROOT_W + 1)'(s_root) + 1'b1) >> 1);
      pp_d        <= CW'(s_root) << 1;
      for (int k = 0; k < 3; k++) begin
        pp_neg[k] <= s_num[k][NUM_W-1];
        pp_n[k]   <= (CW'(s_num[k][NUM_W-1] ? NUM_W'(-s_num[k]) : s_num[k]) << FRAC_BITS)
                     + CW'(s_root);
      end
    end
  end

  // restoring division, one quotient bit per stage
  logic               dv_vld  [0:QB];
  rmq_info_t          dv_info [0:QB];
  logic [ROOT_W-1:0]  dv_lead [0:QB];
  logic [CW-1:0]      dv_d    [0:QB];
  logic [2:0][CW-1:0] dv_rem  [0:QB];
  logic [2:0][QB-1:0] dv_q    [0:QB];
  logic [2:0]         dv_ovf  [0:QB];
  logic [2:0]         dv_neg  [0:QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (adv) begin
      dv_vld[0] <= pp_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_info[0] <= pp_info;
      dv_lead[0] <= pp_lead;
      dv_d[0]    <= pp_d;
      dv_rem[0]  <= pp_n;
      dv_q[0]    <= '0;
      dv_neg[0]  <= pp_neg;
      for (int k = 0; k < 3; k++) begin
        dv_ovf[0][k] <= (pp_n[k] >= (pp_d << QB));
      end
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_div
    localparam logic [QB-1:0] QBIT = QB'(1) << (QB - j);
    logic [CW-1:0] dsh;
    assign dsh = dv_d[j-1] << (QB - j);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[j] <= 1'b0;
      end else if (adv) begin
        dv_vld[j] <= dv_vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_info[j] <= dv_info[j-1];
        dv_lead[j] <= dv_lead[j-1];
        dv_d[j]    <= dv_d[j-1];
        dv_ovf[j]  <= dv_ovf[j-1];
        dv_neg[j]  <= dv_neg[j-1];
        for (int k = 0; k < 3; k++) begin
          if (dv_rem[j-1][k] >= dsh) begin
            dv_rem[j][k] <= dv_rem[j-1][k] - dsh;
            dv_q[j][k]   <= dv_q[j-1][k] | QBIT;
          end else begin
            dv_rem[j][k] <= dv_rem[j-1][k];
            dv_q[j][k]   <= dv_q[j-1][k];
          end
        end
      end
    end
  end

  // saturate and place components
  logic [2:0][FIELD_W-1:0] f_oth;
  logic [FIELD_W-1:0]      f_lead;
  logic [FIELD_W-1:0]      f_x, f_y, f_z, f_w;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dv_ovf[QB][k] || dv_q[QB][k][QB-1]) begin
        f_oth[k] = dv_neg[QB][k] ? Q_MIN : Q_MAX;
      end else begin
        f_oth[k] = dv_neg[QB][k] ? FIELD_W'(-dv_q[QB][k]) : dv_q[QB][k];
      end
    end
    f_lead = (32'(dv_lead[QB]) > 32'(Q_MAX)) ? Q_MAX : FIELD_W'(dv_lead[QB]);
    case (dv_info[QB].branch)
      BR_TRACE: begin
        f_x = f_oth[0]; f_y = f_oth[1]; f_z = f_oth[2]; f_w = f_lead;
      end
      BR_X: begin
        f_x = f_lead; f_y = f_oth[0]; f_z = f_oth[1]; f_w = f_oth[2];
      end
      BR_Y: begin
        f_x = f_oth[0]; f_y = f_lead; f_z = f_oth[1]; f_w = f_oth[2];
      end
      default: begin
        f_x = f_oth[0]; f_y = f_oth[1]; f_z = f_lead; f_w = f_oth[2];
      end
    endcase
    if (dv_info[QB].bad) begin
      f_x = '0; f_y = '0; f_z = '0; f_w = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= dv_vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quat.qx           <= f_x;
      quat.qy           <= f_y;
      quat.qz           <= f_z;
      quat.qw           <= f_w;
      quat.branch_taken <= dv_info[QB].branch;
      quat.invalid      <= dv_info[QB].bad;
    end
  end

  assign quat.valid = out_vld;

endmodule

>>> dv/tb_rotation_matrix_to_quaternion.sv
// Testbench for rotation_matrix_to_quaternion: random and directed matrices,
// with a fixed-point quaternion predictor checked against every output beat.
// Depends on rmq_pkg, rmq_if and the block RTL.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;
  import rmq_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam int LATENCY = 60;

  typedef logic signed [FIELD_W-1:0] fld_t;

  typedef struct {
    fld_t m[9];
  } matrix_t;

  typedef struct {
    fld_t       q[4];
    logic [1:0] branch;
    logic       bad;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rmq_mat_if  mat();
  rmq_quat_if quat();

  rotation_matrix_to_quaternion dut (
    .clk  (clk),
    .rst  (rst),
    .mat  (mat.sink),
    .quat (quat.source)
  );

  always #5 clk = ~clk;

  matrix_t pending_mats[$];
  quat_t   expected_quats[$];
  int      errors = 0;
  bit      calm = 1'b0;
  int      send_gap = 0;
  int      recv_gap = 0;

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic fld_t clamp18(longint v);
    if (v > 131071) return fld_t'(131071);
    if (v < -131072) return fld_t'(-131072);
    return fld_t'(v);
  endfunction

  // Divide by twice the root, rounding ties away from zero.
  function automatic fld_t ratio_to_root(longint n, longint root);
    longint mag;
    longint qv;
    mag = (n < 0) ? -n : n;
    qv = ((mag <<< FB) + root) / (root * 2);
    if (qv > 64'sd2147483647) qv = 64'sd2147483647;
    return clamp18((n < 0) ? -qv : qv);
  endfunction

  function automatic quat_t matrix_to_quat(matrix_t a);
    quat_t   r;
    longint  m[9];
    longint  n[3];
    longint  rad;
    longint  root;
    int      lead;
    int      k;
    for (int i = 0; i < 9; i++) m[i] = longint'(a.m[i]);
    rad = m[0] + m[4] + m[8] + ONE;
    if (rad > 0) begin
      r.branch = BR_TRACE; lead = 3;
      n[0] = m[5] - m[7]; n[1] = m[6] - m[2]; n[2] = m[1] - m[3];
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      r.branch = BR_X; lead = 0;
      rad = ONE + m[0] - m[4] - m[8];
      n[0] = m[3] + m[1]; n[1] = m[6] + m[2]; n[2] = m[5] - m[7];
    end else if (m[4] > m[8]) begin
      r.branch = BR_Y; lead = 1;
      rad = ONE + m[4] - m[0] - m[8];
      n[0] = m[3] + m[1]; n[1] = m[7] + m[5]; n[2] = m[6] - m[2];
    end else begin
      r.branch = BR_Z; lead = 2;
      rad = ONE + m[8] - m[0] - m[4];
      n[0] = m[6] + m[2]; n[1] = m[7] + m[5]; n[2] = m[1] - m[3];
    end
    for (int i = 0; i < 4; i++) r.q[i] = '0;
    r.bad = 1'b0;
    root = (rad > 0) ? int_sqrt(longint'(rad) <<< FB) : 0;
    if (root == 0) begin
      r.bad = 1'b1;
    end else begin
      r.q[lead] = clamp18((root + 1) >>> 1);
      k = 0;
      for (int i = 0; i < 4; i++) begin
        if (i != lead) begin
          r.q[i] = ratio_to_root(n[k], root);
          k++;
        end
      end
    end
    return r;
  endfunction

  function automatic fld_t rand_field();
    case ($urandom_range(0, 5))
      0: return fld_t'(131071);
      1: return fld_t'(-131072);
      2: return fld_t'($urandom_range(0, 2 * ONE) - ONE);
      default: return fld_t'($urandom);
    endcase
  endfunction

  // Rotation-like matrix around one axis, with small random offsets on some entries.
  function automatic matrix_t rand_rotation();
    matrix_t a;
    real th, c, s;
    int ax;
    th = ($urandom_range(0, 62831) / 10000.0);
    c = $cos(th); s = $sin(th);
    ax = $urandom_range(0, 2);
    for (int i = 0; i < 9; i++) a.m[i] = '0;
    a.m[ax * 4] = fld_t'(ONE);
    if (ax == 0) begin
      a.m[4] = fld_t'($rtoi(c * ONE)); a.m[5] = fld_t'(-$rtoi(s * ONE));
      a.m[7] = fld_t'($rtoi(s * ONE)); a.m[8] = fld_t'($rtoi(c * ONE));
    end else if (ax == 1) begin
      a.m[0] = fld_t'($rtoi(c * ONE)); a.m[2] = fld_t'($rtoi(s * ONE));
      a.m[6] = fld_t'(-$rtoi(s * ONE)); a.m[8] = fld_t'($rtoi(c * ONE));
    end else begin
      a.m[0] = fld_t'($rtoi(c * ONE)); a.m[1] = fld_t'(-$rtoi(s * ONE));
      a.m[3] = fld_t'($rtoi(s * ONE)); a.m[4] = fld_t'($rtoi(c * ONE));
    end
    for (int i = 0; i < 9; i++)
      if ($urandom_range(0, 7) == 0) a.m[i] = a.m[i] + fld_t'($urandom_range(0, 63) - 32);
    return a;
  endfunction

  function automatic matrix_t diag(longint d0, longint d1, longint d2, longint off);
    matrix_t a;
    for (int i = 0; i < 9; i++) a.m[i] = fld_t'(off * (i + 1) * ((i % 2) ? -1 : 1));
    a.m[0] = fld_t'(d0); a.m[4] = fld_t'(d1); a.m[8] = fld_t'(d2);
    return a;
  endfunction

  initial begin
    matrix_t a;
    // identity, 180-degree turns about each axis, leader ties, bad radicands
    pending_mats.push_back(diag(ONE, ONE, ONE, 0));
    pending_mats.push_back(diag(ONE, -ONE, -ONE, 0));
    pending_mats.push_back(diag(-ONE, ONE, -ONE, 0));
    pending_mats.push_back(diag(-ONE, -ONE, ONE, 0));
    pending_mats.push_back(diag(-ONE, -ONE, -ONE, 100));
    pending_mats.push_back(diag(-ONE / 2, -ONE / 2, -ONE / 2, 50));
    pending_mats.push_back(diag(0, 0, -ONE, 300));
    pending_mats.push_back(diag(-ONE, 0, 0, 300));
    pending_mats.push_back(diag(-131072, -131072, -131072, 0));
    pending_mats.push_back(diag(-131072, 131071, -131072, 131071));
    pending_mats.push_back(diag(131071, -131072, -131072, -131072));
    pending_mats.push_back(diag(-131072, -131072, 131071, 131071));
    pending_mats.push_back(diag(-ONE - 5, -ONE, 0, 2));
    pending_mats.push_back(diag(-2 * ONE, -ONE / 4, -ONE / 4, 7));
    pending_mats.push_back(diag(-ONE + 1, 0, -1, 9));
    pending_mats.push_back(diag(131071, 131071, 131071, 131071));
    pending_mats.push_back(diag(-ONE, -ONE, ONE - 1, -131072));
    for (int i = 0; i < 9; i++) a.m[i] = fld_t'(131071);
    pending_mats.push_back(a);
    for (int i = 0; i < 9; i++) a.m[i] = fld_t'(-131072);
    pending_mats.push_back(a);
    for (int i = 0; i < 1000; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: a = rand_rotation();
        6: a = diag(-$urandom_range(0, 3 * ONE), -$urandom_range(0, 3 * ONE),
                    -$urandom_range(0, 3 * ONE), $urandom_range(0, 4000));
        default: for (int j = 0; j < 9; j++) a.m[j] = rand_field();
      endcase
      pending_mats.push_back(a);
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: advance the queue on each accepted beat.
  always @(posedge clk) begin
    matrix_t a;
    if (rst) begin
      mat.valid <= 1'b0;
      mat.m00 <= '0; mat.m01 <= '0; mat.m02 <= '0;
      mat.m10 <= '0; mat.m11 <= '0; mat.m12 <= '0;
      mat.m20 <= '0; mat.m21 <= '0; mat.m22 <= '0;
    end else begin
      if (mat.valid && mat.ready) begin
        expected_quats.push_back(matrix_to_quat(pending_mats.pop_front()));
        if (pending_mats.size() < 150) calm = 1'b1;
      end
      if (!(mat.valid && !mat.ready)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          mat.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 7);
          mat.valid <= 1'b0;
        end else if (pending_mats.size() > 0) begin
          a = pending_mats[0];
          mat.valid <= 1'b1;
          mat.m00 <= a.m[0]; mat.m01 <= a.m[1]; mat.m02 <= a.m[2];
          mat.m10 <= a.m[3]; mat.m11 <= a.m[4]; mat.m12 <= a.m[5];
          mat.m20 <= a.m[6]; mat.m21 <= a.m[7]; mat.m22 <= a.m[8];
        end else begin
          mat.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output beat against the oldest prediction.
  always @(posedge clk) begin
    quat_t e;
    fld_t  got[4];
    if (rst) begin
      quat.ready <= 1'b0;
    end else begin
      if (quat.valid && quat.ready) begin
        got[0] = quat.qx; got[1] = quat.qy; got[2] = quat.qz; got[3] = quat.qw;
        if (expected_quats.size() == 0) begin
          $display("%0t: unexpected beat qx=%0d qy=%0d qz=%0d qw=%0d", $time,
                   quat.qx, quat.qy, quat.qz, quat.qw);
          errors++;
        end else begin
          e = expected_quats.pop_front();
          for (int i = 0; i < 4; i++)
            if (got[i] !== e.q[i]) begin
              $display("%0t: q[%0d] expected %0d actual %0d", $time, i, e.q[i], got[i]);
              errors++;
            end
          if (quat.branch_taken !== e.branch) begin
            $display("%0t: branch expected %0d actual %0d", $time, e.branch,
                     quat.branch_taken);
            errors++;
          end
          if (quat.invalid !== e.bad) begin
            $display("%0t: invalid expected %0b actual %0b", $time, e.bad, quat.invalid);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        quat.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 7);
        quat.ready <= 1'b0;
      end else begin
        quat.ready <= 1'b1;
      end
    end
  end

  initial begin
    @(negedge rst);
    wait (pending_mats.size() == 0 && expected_quats.size() == 0);
    repeat (LATENCY * 2) @(posedge clk);
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> rotation_matrix_to_quaternion.f
rtl/rmq_pkg.sv
rtl/rmq_if.sv
rtl/rmq_front.sv
rtl/rmq_queue.sv
rtl/rmq_back.sv
rtl/rotation_matrix_to_quaternion.sv
dv/tb_rotation_matrix_to_quaternion.sv
